// File: src/hrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrf_pkg;

    // Internal counter widths
    localparam int LINE_COUNT_WIDTH  = 16;
    localparam int BODY_LENGTH_WIDTH = 24;

    // Fixed field widths of the ports
    localparam int MAX_LINE_W   = 16;
    localparam int MAX_BODY_W   = 24;
    localparam int BODY_FIELD_W = 24;
    localparam int PHASE_W      = 3;
    localparam int ERROR_W      = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LINE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BODY = 1'd1;
    localparam logic [MAX_LINE_W-1:0]  MAX_LINE_RESET = MAX_LINE_W'(8 * 1024);
    localparam logic [MAX_BODY_W-1:0]  MAX_BODY_RESET = MAX_BODY_W'(1 * 1024 * 1024);

    // Operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Queue between classifier and parser
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Character codes
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // Header names that are recognized
    localparam int CL_LEN = 14;
    localparam int TE_LEN = 17;
    localparam logic [8*CL_LEN-1:0] CL_NAME = "Content-Length";
    localparam logic [8*TE_LEN-1:0] TE_NAME = "Transfer-Encoding";
    localparam int NAME_POS_W = 5;
    localparam logic [NAME_POS_W-1:0] NAME_POS_MAX = '1;

    typedef enum logic [PHASE_W-1:0] {
        PH_STATUS  = 3'd0,
        PH_HEADERS = 3'd1,
        PH_BODY    = 3'd2,
        PH_DONE    = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    typedef enum logic [ERROR_W-1:0] {
        ERR_NONE       = 3'd0,
        ERR_LINE_LONG  = 3'd1,
        ERR_NO_COLON   = 3'd2,
        ERR_BAD_LENGTH = 3'd3,
        ERR_BODY_BIG   = 3'd4,
        ERR_CHUNKED    = 3'd5,
        ERR_NO_LENGTH  = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        SEP_NONE   = 2'd0,
        SEP_COLON  = 2'd1,
        SEP_FOUND  = 2'd2,
        SEP_LENGTH = 2'd3
    } sep_t;

    typedef enum logic [1:0] {
        VAL_LEAD   = 2'd0,
        VAL_DIGITS = 2'd1,
        VAL_TRAIL  = 2'd2,
        VAL_BAD    = 2'd3
    } val_t;

    // Byte with its precomputed character classes
    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
        logic       is_space;
        logic       is_ows;
        logic       is_digit;
        logic [3:0] digit;
    } byte_class_t;

    typedef struct packed {
        logic        restart;
        byte_class_t cls;
    } item_t;

    typedef struct packed {
        phase_t                       phase;
        logic [LINE_COUNT_WIDTH-1:0]  line_len;
        logic                         prev_cr;
        sep_t                         sep;
        logic [NAME_POS_W-1:0]        name_pos;
        logic [1:0]                   match;
        logic                         len_seen;
        logic                         enc_seen;
        val_t                         vstate;
        logic [BODY_LENGTH_WIDTH-1:0] len_val;
        logic                         len_big;
        logic [BODY_LENGTH_WIDTH-1:0] body_cnt;
        err_t                         err;
    } parse_state_t;

    typedef struct packed {
        phase_t                  phase;
        err_t                    error_code;
        logic                    line_end;
        logic                    body_valid;
        logic [BODY_FIELD_W-1:0] body_offset;
        logic [BODY_FIELD_W-1:0] content_length;
        logic                    complete;
    } result_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        c.data     = b;
        c.is_cr    = (b == CHR_CR);
        c.is_lf    = (b == CHR_LF);
        c.is_colon = (b == CHR_COLON);
        c.is_space = (b == CHR_SPACE);
        c.is_ows   = (b == CHR_SPACE) || (b == CHR_TAB);
        c.is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
        c.digit    = c.is_digit ? 4'(b - CHR_ZERO) : 4'd0;
        return c;
    endfunction

    localparam byte_class_t CR_CLASS = classify(CHR_CR);

    // Does byte b match the name character at position pos
    function automatic logic cl_match(input logic [NAME_POS_W-1:0] pos, input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if (int'(pos) < CL_LEN) begin
            ok = (CL_NAME[8*(CL_LEN-1-int'(pos)) +: 8] == b);
        end
        return ok;
    endfunction

    function automatic logic te_match(input logic [NAME_POS_W-1:0] pos, input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if (int'(pos) < TE_LEN) begin
            ok = (TE_NAME[8*(TE_LEN-1-int'(pos)) +: 8] == b);
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: src/hrf_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hrf_item_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

`default_nettype wire

// File: src/hrf_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hrf_result_if
    import hrf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [PHASE_W-1:0]      phase;
    logic [ERROR_W-1:0]      error_code;
    logic                    line_end;
    logic                    body_valid;
    logic [BODY_FIELD_W-1:0] body_offset;
    logic [BODY_FIELD_W-1:0] content_length;
    logic                    complete;

    modport source (
        output valid, output phase, output error_code, output line_end,
        output body_valid, output body_offset, output content_length, output complete,
        input ready
    );
    modport sink (
        input valid, input phase, input error_code, input line_end,
        input body_valid, input body_offset, input content_length, input complete,
        output ready
    );
endinterface

`default_nettype wire

// File: src/hrf_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hrf_cfg_if
    import hrf_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/http_response_framer.sv
// HTTP/1.1 response framer. Each transfer on item carries one response byte or a
// restart; each produces exactly one transfer on result that shows the parse phase,
// the sticky error code, line-end and body-byte flags with the body offset, and the
// accepted Content-Length. Throughput is one byte per clock when result is not
// stalled: the parser in the back end handles every byte, including a deferred CR,
// combinationally, and a two-entry queue plus a result register let input and
// output stall independently. An item is written into the queue and then parsed
// into the result register. The two limit registers (max line length at index 0,
// max body length at index 1) are written through cfg and survive a restart; the
// user must write them only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module http_response_framer
    import hrf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hrf_item_if.sink      item,
    hrf_result_if.source  result,
    hrf_cfg_if.sink       cfg
);

    logic  push_valid;
    item_t push_data;
    logic  push_ready;
    logic  q_valid;
    item_t q_data;
    logic  q_pop;

    // Classifier
    hrf_front u_front (
        .item       (item),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // Decoupling queue
    hrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_data  (push_data),
        .wr_ready (push_ready),
        .rd_valid (q_valid),
        .rd_data  (q_data),
        .rd_pop   (q_pop)
    );

    // Parser and result register
    hrf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: src/hrf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hrf_front
    import hrf_pkg::*;
(
    hrf_item_if.sink item,
    output logic     push_valid,
    output item_t    push_data,
    input  logic     push_ready
);

    // Accept while the queue has room
    assign item.ready = push_ready;
    assign push_valid = item.valid;

    // Decode the operation and tag the byte with its character classes
    always_comb
    begin
        push_data.restart = (item.operation == OP_RESTART);
        push_data.cls     = classify(item.data_byte);
    end

endmodule

`default_nettype wire

// File: src/hrf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hrf_queue
    import hrf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    input  item_t wr_data,
    output logic  wr_ready,
    output logic  rd_valid,
    output item_t rd_data,
    input  logic  rd_pop
);

    item_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 do_push;
    logic                 do_pop;

    assign wr_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign do_push  = wr_valid && wr_ready;
    assign do_pop   = rd_pop && rd_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: src/hrf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hrf_back
    import hrf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  item_t           q_data,
    output logic            q_pop,
    hrf_cfg_if.sink         cfg,
    hrf_result_if.source    result
);

    localparam parse_state_t CLEAR_STATE = '{
        phase:    PH_STATUS,
        line_len: '0,
        prev_cr:  1'b0,
        sep:      SEP_NONE,
        name_pos: '0,
        match:    2'b11,
        len_seen: 1'b0,
        enc_seen: 1'b0,
        vstate:   VAL_LEAD,
        len_val:  '0,
        len_big:  1'b0,
        body_cnt: '0,
        err:      ERR_NONE
    };

    logic [MAX_LINE_W-1:0] max_line_reg;
    logic [MAX_BODY_W-1:0] max_body_reg;
    parse_state_t          state_reg;
    parse_state_t          state_next;
    parse_state_t          step_state;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_data_reg;
    result_t               out_data_next;
    logic                  advance;
    logic                  step_line_end;
    logic                  step_body_valid;
    logic [BODY_LENGTH_WIDTH-1:0] step_body_off;

    // Content-Length digit accumulation and syntax tracking
    function automatic parse_state_t value_byte(input parse_state_t s, input byte_class_t c);
        logic [BODY_LENGTH_WIDTH+3:0] v;
        v = ({4'd0, s.len_val} << 3) + ({4'd0, s.len_val} << 1)
            + (BODY_LENGTH_WIDTH+4)'(c.digit);
        if (s.vstate == VAL_LEAD || s.vstate == VAL_DIGITS)
        begin
            if (c.is_digit)
            begin
                if (v[BODY_LENGTH_WIDTH+3:BODY_LENGTH_WIDTH] != 4'd0)
                begin
                    s.len_big = 1'b1;
                    s.len_val = '1;
                end
                else
                begin
                    s.len_val = v[BODY_LENGTH_WIDTH-1:0];
                end
                s.vstate = VAL_DIGITS;
            end
            else if (c.is_ows)
            begin
                s.vstate = (s.vstate == VAL_DIGITS) ? VAL_TRAIL : VAL_LEAD;
            end
            else
            begin
                s.vstate = VAL_BAD;
            end
        end
        else if (s.vstate == VAL_TRAIL && !c.is_ows)
        begin
            s.vstate = VAL_BAD;
        end
        return s;
    endfunction

    // Header name matching and ": " separator detection
    function automatic parse_state_t header_byte(input parse_state_t s, input byte_class_t c);
        logic handled;
        logic is_cl;
        logic is_te;
        handled = 1'b0;
        is_cl   = s.match[0] && (s.name_pos == NAME_POS_W'(CL_LEN));
        is_te   = s.match[1] && (s.name_pos == NAME_POS_W'(TE_LEN));
        if (s.sep == SEP_FOUND || s.sep == SEP_LENGTH)
        begin
            if (s.sep == SEP_LENGTH)
            begin
                s = value_byte(s, c);
            end
        end
        else
        begin
            if (s.sep == SEP_COLON)
            begin
                if (c.is_space)
                begin
                    s.sep = SEP_FOUND;
                    if (is_cl && !s.len_seen)
                    begin
                        s.len_seen = 1'b1;
                        s.sep      = SEP_LENGTH;
                        s.vstate   = VAL_LEAD;
                        s.len_val  = '0;
                        s.len_big  = 1'b0;
                    end
                    if (is_te)
                    begin
                        s.enc_seen = 1'b1;
                    end
                    handled = 1'b1;
                end
                else
                begin
                    s.match = 2'b00;
                    s.sep   = SEP_NONE;
                end
            end
            if (!handled)
            begin
                if (c.is_colon)
                begin
                    s.sep = SEP_COLON;
                end
                else
                begin
                    if (!cl_match(s.name_pos, c.data))
                    begin
                        s.match[0] = 1'b0;
                    end
                    if (!te_match(s.name_pos, c.data))
                    begin
                        s.match[1] = 1'b0;
                    end
                    if (s.name_pos != NAME_POS_MAX)
                    begin
                        s.name_pos = s.name_pos + 1'b1;
                    end
                end
            end
        end
        return s;
    endfunction

    // Count one line byte, check the line limit
    function automatic parse_state_t line_byte(input parse_state_t s, input byte_class_t c,
                                               input logic [MAX_LINE_W-1:0] max_line);
        if (32'(s.line_len) >= 32'(max_line) || (&s.line_len))
        begin
            s.phase = PH_ERROR;
            s.err   = ERR_LINE_LONG;
        end
        else
        begin
            s.line_len = s.line_len + 1'b1;
            if (s.phase == PH_HEADERS)
            begin
                s = header_byte(s, c);
            end
        end
        return s;
    endfunction

    // Blank line: decide how the body is framed
    function automatic parse_state_t end_headers(input parse_state_t s,
                                                 input logic [MAX_BODY_W-1:0] max_body);
        if (s.len_seen)
        begin
            if (s.vstate != VAL_DIGITS && s.vstate != VAL_TRAIL)
            begin
                s.phase = PH_ERROR;
                s.err   = ERR_BAD_LENGTH;
            end
            else if (s.len_big || (32'(s.len_val) > 32'(max_body)))
            begin
                s.phase = PH_ERROR;
                s.err   = ERR_BODY_BIG;
            end
            else
            begin
                s.phase = (s.len_val == '0) ? PH_DONE : PH_BODY;
            end
        end
        else if (s.enc_seen)
        begin
            s.phase = PH_ERROR;
            s.err   = ERR_CHUNKED;
        end
        else
        begin
            s.phase = PH_ERROR;
            s.err   = ERR_NO_LENGTH;
        end
        return s;
    endfunction

    // CR LF closes the current line
    function automatic parse_state_t end_line(input parse_state_t s,
                                              input logic [MAX_BODY_W-1:0] max_body);
        if (s.phase == PH_STATUS)
        begin
            s.phase = PH_HEADERS;
        end
        else if (s.line_len == '0)
        begin
            s = end_headers(s, max_body);
        end
        else if (s.sep == SEP_NONE || s.sep == SEP_COLON)
        begin
            s.phase = PH_ERROR;
            s.err   = ERR_NO_COLON;
        end
        s.line_len = '0;
        s.prev_cr  = 1'b0;
        s.sep      = SEP_NONE;
        s.name_pos = '0;
        s.match    = 2'b11;
        return s;
    endfunction

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg <= MAX_LINE_RESET;
            max_body_reg <= MAX_BODY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_LINE: max_line_reg <= cfg.data[MAX_LINE_W-1:0];
                CFG_MAX_BODY: max_body_reg <= cfg.data[MAX_BODY_W-1:0];
                default:      ;
            endcase
        end
    end

    // Process the queue head whenever the output register can take a result
    assign advance = q_valid && (!out_valid_reg || result.ready);
    assign q_pop   = advance;

    // One parse step per byte
    always_comb
    begin
        step_state      = state_reg;
        step_line_end   = 1'b0;
        step_body_valid = 1'b0;
        step_body_off   = '0;
        if (q_data.restart)
        begin
            step_state = CLEAR_STATE;
        end
        else if (state_reg.phase == PH_STATUS || state_reg.phase == PH_HEADERS)
        begin
            if (q_data.cls.is_lf && state_reg.prev_cr)
            begin
                step_line_end = 1'b1;
                step_state    = end_line(state_reg, max_body_reg);
            end
            else
            begin
                // A pending CR not followed by LF counts as a line byte
                if (step_state.prev_cr)
                begin
                    step_state.prev_cr = 1'b0;
                    step_state = line_byte(step_state, CR_CLASS, max_line_reg);
                end
                if (step_state.phase != PH_ERROR)
                begin
                    if (q_data.cls.is_cr)
                    begin
                        step_state.prev_cr = 1'b1;
                    end
                    else
                    begin
                        step_state = line_byte(step_state, q_data.cls, max_line_reg);
                    end
                end
            end
        end
        else if (state_reg.phase == PH_BODY)
        begin
            step_body_valid     = 1'b1;
            step_body_off       = state_reg.body_cnt;
            step_state.body_cnt = state_reg.body_cnt + 1'b1;
            if (step_state.body_cnt == state_reg.len_val)
            begin
                step_state.phase = PH_DONE;
            end
        end
    end

    // Result and next-state selection
    always_comb
    begin
        state_next     = advance ? step_state : state_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        out_data_next.phase       = step_state.phase;
        out_data_next.error_code  = step_state.err;
        out_data_next.line_end    = step_line_end;
        out_data_next.body_valid  = step_body_valid;
        out_data_next.body_offset = BODY_FIELD_W'(step_body_off);
        out_data_next.content_length =
            (step_state.phase == PH_BODY || step_state.phase == PH_DONE)
            ? BODY_FIELD_W'(step_state.len_val) : '0;
        out_data_next.complete    = (step_state.phase == PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLEAR_STATE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Drive the result channel
    assign result.valid          = out_valid_reg;
    assign result.phase          = out_data_reg.phase;
    assign result.error_code     = out_data_reg.error_code;
    assign result.line_end       = out_data_reg.line_end;
    assign result.body_valid     = out_data_reg.body_valid;
    assign result.body_offset    = out_data_reg.body_offset;
    assign result.content_length = out_data_reg.content_length;
    assign result.complete       = out_data_reg.complete;

endmodule

`default_nettype wire

// File: src/hrf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hrf_checker
    import hrf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [PHASE_W-1:0]      phase,
    input logic [ERROR_W-1:0]      error_code,
    input logic                    body_valid,
    input logic [BODY_FIELD_W-1:0] body_offset,
    input logic [BODY_FIELD_W-1:0] content_length,
    input logic                    complete
);

    // Complete flag agrees with the phase
    a_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (complete == (phase == PH_DONE)))
        else $error("complete flag disagrees with phase");

    // Error code is set exactly in the error phase
    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((error_code != ERR_NONE) == (phase == PH_ERROR)))
        else $error("error code disagrees with phase");

    // Body bytes and a known length only once framing is settled
    a_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (body_valid || content_length != '0)
        |-> (phase == PH_BODY || phase == PH_DONE))
        else $error("body data outside body phase");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(body_offset))
        else $error("stalled result changed");

endmodule

bind http_response_framer hrf_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .phase          (result.phase),
    .error_code     (result.error_code),
    .body_valid     (result.body_valid),
    .body_offset    (result.body_offset),
    .content_length (result.content_length),
    .complete       (result.complete)
);

`default_nettype wire
